[design/lgms_pkg.sv]
// ----------------------------------------------------------------------------
// lgms_pkg
// types, constants and helper functions for the lift and grip sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lgms_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned JOY_W   = 10;
    localparam int unsigned LIGHT_W = 10;
    localparam int unsigned DRIVE_W = 9;
    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned THR_W   = 10;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] REG_LIGHT_THRESHOLD = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LIFT_DISTANCE   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_GRIP_ANGLE      = 2'd2;

    localparam logic [THR_W-1:0]   RST_LIGHT_THRESHOLD = 10'd80;
    localparam logic [DIST_W-1:0]  RST_LIFT_DISTANCE   = 16'd424;
    localparam logic [ANGLE_W-1:0] RST_GRIP_ANGLE      = 8'd90;
    localparam logic [POS_W-1:0]   RST_HOME_POS        = 32'hFFFF_FC19;

    localparam logic [DRIVE_W-1:0] DRIVE_UP   = 9'sd255;
    localparam logic [DRIVE_W-1:0] DRIVE_DOWN = -9'sd255;
    localparam logic [DRIVE_W-1:0] DRIVE_STOP = '0;
    localparam logic [ANGLE_W-1:0] SERVO_MAX  = 8'd180;

    localparam logic [CODE_W-1:0] CODE_CALIBRATE   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_WAIT_LIGHT  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_LIFTING     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_CLOSING     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_WAIT_BUTTON = 3'd4;
    localparam logic [CODE_W-1:0] CODE_OPENING     = 3'd5;
    localparam logic [CODE_W-1:0] CODE_LOWERING    = 3'd6;

    typedef enum logic [6:0] {
        PH_CALIBRATE   = 7'b000_0001,
        PH_WAIT_LIGHT  = 7'b000_0010,
        PH_LIFTING     = 7'b000_0100,
        PH_CLOSING     = 7'b000_1000,
        PH_WAIT_BUTTON = 7'b001_0000,
        PH_OPENING     = 7'b010_0000,
        PH_LOWERING    = 7'b100_0000
    } t_phase;

    function automatic logic [CODE_W-1:0] phase_code(input t_phase ph);
        logic [CODE_W-1:0] code;
        unique case (ph)
            PH_CALIBRATE:   code = CODE_CALIBRATE;
            PH_WAIT_LIGHT:  code = CODE_WAIT_LIGHT;
            PH_LIFTING:     code = CODE_LIFTING;
            PH_CLOSING:     code = CODE_CLOSING;
            PH_WAIT_BUTTON: code = CODE_WAIT_BUTTON;
            PH_OPENING:     code = CODE_OPENING;
            PH_LOWERING:    code = CODE_LOWERING;
            default:        code = CODE_CALIBRATE;
        endcase
        return code;
    endfunction

    // floor(joy * 510 / 1023): shift estimate plus one correction step
    function automatic logic [8:0] joy_scale(input logic [JOY_W-1:0] joy);
        logic [18:0] prod;
        logic [8:0]  q_est;
        logic [10:0] rem;
        prod  = {joy, 9'b0} - {8'b0, joy, 1'b0};
        q_est = prod[18:10];
        rem   = {1'b0, prod[9:0]} + {2'b0, q_est};
        return (rem >= 11'd1023) ? q_est + 9'd1 : q_est;
    endfunction

    function automatic logic [DRIVE_W-1:0] joy_drive(input logic [JOY_W-1:0] joy);
        logic [DRIVE_W:0] full;
        full = 10'sd255 - {1'b0, joy_scale(joy)};
        return full[DRIVE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/lift_grip_motion_sequencer.sv]
// ----------------------------------------------------------------------------
// lift_grip_motion_sequencer
// per-tick sequencer for a lift and gripper: calibrate, lift on light,
// grip, wait for button, release and lower back to the origin
// ----------------------------------------------------------------------------
//  channel  | handshake                 | beat
//  ---------+---------------------------+-------------------------------------
//  sample   | i_in_valid / o_in_stall   | encoder, joystick, light, button
//  result   | o_out_valid / i_out_stall | drive, servo angle, phase, origin
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  one beat per cycle while no stall holds; a beat waits in the input register,
//  where the state update runs, and moves to the result register once that
//  register is empty or its beat is not stalled
//  synchronous active-low reset sets state and config to their reset values and clears both valid flags
//  a stalled result holds; the input register still takes one more beat
// ----------------------------------------------------------------------------
`default_nettype none

module lift_grip_motion_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [lgms_pkg::POS_W-1:0]   i_encoder_pos,
    input  wire logic [lgms_pkg::JOY_W-1:0]     i_joystick_y,
    input  wire logic [lgms_pkg::LIGHT_W-1:0]   i_light_level,
    input  wire logic                           i_button_level,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [lgms_pkg::DRIVE_W-1:0] o_motor_drive,
    output logic [lgms_pkg::ANGLE_W-1:0]        o_servo_angle,
    output logic [lgms_pkg::CODE_W-1:0]         o_phase_code,
    output logic signed [lgms_pkg::POS_W-1:0]   o_origin_pos,
    input  wire logic                           i_cfg_we,
    input  wire logic [lgms_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [lgms_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [lgms_pkg::THR_W-1:0]   r_light_threshold;
    logic [lgms_pkg::DIST_W-1:0]  r_lift_distance;
    logic [lgms_pkg::ANGLE_W-1:0] r_grip_angle;

    logic                           r_in_valid;
    logic [lgms_pkg::POS_W-1:0]     r_pos;
    logic [lgms_pkg::JOY_W-1:0]     r_joy;
    logic [lgms_pkg::LIGHT_W-1:0]   r_light;
    logic                           r_press;

    lgms_pkg::t_phase               r_phase, n_phase;
    logic [lgms_pkg::POS_W-1:0]     r_home, n_home;
    logic [lgms_pkg::JOY_W-1:0]     r_last_joy, n_last_joy;
    logic [lgms_pkg::DRIVE_W-1:0]   r_drive, n_drive;
    logic [lgms_pkg::ANGLE_W-1:0]   r_angle, n_angle;

    logic                           r_out_valid;
    logic [lgms_pkg::DRIVE_W-1:0]   r_out_drive;
    logic [lgms_pkg::ANGLE_W-1:0]   r_out_angle;
    logic [lgms_pkg::CODE_W-1:0]    r_out_code;
    logic [lgms_pkg::POS_W-1:0]     r_out_home;

    logic out_ready;
    logic fire;
    logic in_take;
    logic lift_done;
    logic [lgms_pkg::POS_W:0] lift_delta;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    assign lift_delta = {r_pos[lgms_pkg::POS_W-1], r_pos}
                      - {r_home[lgms_pkg::POS_W-1], r_home};
    assign lift_done  = $signed(lift_delta)
                      >= $signed({{(lgms_pkg::POS_W + 1 - lgms_pkg::DIST_W){1'b0}},
                                  r_lift_distance});

    always_comb begin
        n_phase    = r_phase;
        n_home     = r_home;
        n_last_joy = r_last_joy;
        n_drive    = r_drive;
        n_angle    = r_angle;
        unique case (r_phase)
            lgms_pkg::PH_CALIBRATE: begin
                if (r_joy != r_last_joy) begin
                    n_last_joy = r_joy;
                    n_drive    = lgms_pkg::joy_drive(r_joy);
                end
                if (r_press) begin
                    n_home  = r_pos;
                    n_phase = lgms_pkg::PH_WAIT_LIGHT;
                end
            end
            lgms_pkg::PH_WAIT_LIGHT: begin
                if (r_light > r_light_threshold) begin
                    n_drive = lgms_pkg::DRIVE_UP;
                    n_phase = lgms_pkg::PH_LIFTING;
                end
            end
            lgms_pkg::PH_LIFTING: begin
                if (lift_done) begin
                    n_drive = lgms_pkg::DRIVE_STOP;
                    n_phase = lgms_pkg::PH_CLOSING;
                end
            end
            lgms_pkg::PH_CLOSING: begin
                n_angle = (r_grip_angle > lgms_pkg::SERVO_MAX) ? lgms_pkg::SERVO_MAX
                                                               : r_grip_angle;
                n_phase = lgms_pkg::PH_WAIT_BUTTON;
            end
            lgms_pkg::PH_WAIT_BUTTON: begin
                if (r_press) begin
                    n_phase = lgms_pkg::PH_OPENING;
                end
            end
            lgms_pkg::PH_OPENING: begin
                n_angle = '0;
                n_drive = lgms_pkg::DRIVE_DOWN;
                n_phase = lgms_pkg::PH_LOWERING;
            end
            lgms_pkg::PH_LOWERING: begin
                if (r_pos == r_home) begin
                    n_drive = lgms_pkg::DRIVE_STOP;
                    n_phase = lgms_pkg::PH_WAIT_LIGHT;
                end
            end
            default: begin
                n_phase = lgms_pkg::PH_CALIBRATE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_threshold <= lgms_pkg::RST_LIGHT_THRESHOLD;
            r_lift_distance   <= lgms_pkg::RST_LIFT_DISTANCE;
            r_grip_angle      <= lgms_pkg::RST_GRIP_ANGLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lgms_pkg::REG_LIGHT_THRESHOLD: r_light_threshold <= i_cfg_data[lgms_pkg::THR_W-1:0];
                lgms_pkg::REG_LIFT_DISTANCE:   r_lift_distance   <= i_cfg_data[lgms_pkg::DIST_W-1:0];
                lgms_pkg::REG_GRIP_ANGLE:      r_grip_angle      <= i_cfg_data[lgms_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pos   <= i_encoder_pos;
            r_joy   <= i_joystick_y;
            r_light <= i_light_level;
            r_press <= i_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lgms_pkg::PH_CALIBRATE;
            r_home     <= lgms_pkg::RST_HOME_POS;
            r_last_joy <= '0;
            r_drive    <= lgms_pkg::DRIVE_STOP;
            r_angle    <= '0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_home     <= n_home;
            r_last_joy <= n_last_joy;
            r_drive    <= n_drive;
            r_angle    <= n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_drive <= n_drive;
            r_out_angle <= n_angle;
            r_out_code  <= lgms_pkg::phase_code(n_phase);
            r_out_home  <= n_home;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motor_drive = r_out_drive;
    assign o_servo_angle = r_out_angle;
    assign o_phase_code  = r_out_code;
    assign o_origin_pos  = r_out_home;

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register lost one-hot form");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive != 9'h100)
        else $error("drive register outside +-255");

    a_angle_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle <= lgms_pkg::SERVO_MAX)
        else $error("servo angle above limit");

    a_close_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_phase == lgms_pkg::PH_CLOSING |=> r_phase == lgms_pkg::PH_WAIT_BUTTON)
        else $error("closing did not advance to wait button");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room downstream");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid && o_phase_code == lgms_pkg::phase_code(r_phase))
        else $error("result beat does not match committed state");
`endif

endmodule

`default_nettype wire
